// File: hdl/gilf_pkg.sv
// shared types and constants of the glacier ice lateral flux block
package gilf_pkg;

  localparam int DIV_W       = 64;
  localparam int EXP_W       = 10;
  localparam int FRONT_LAT   = 6;
  localparam int NORM_LAT    = 3;
  localparam int G_COUNT     = 3;
  localparam int H_COUNT     = 5;
  localparam int MUL_STAGES  = G_COUNT + H_COUNT + 1;
  localparam int LATENCY     = FRONT_LAT + DIV_W + 1 + NORM_LAT + MUL_STAGES + 2;

  localparam logic [31:0] K_MANT    = 32'd2391936205;
  localparam logic signed [EXP_W-1:0] K_EXP = -10'sd215;
  localparam logic [9:0]  ICE_NUM   = 10'd1000;
  localparam logic [31:0] ICE_RECIP = 32'd2398062437;
  localparam int          ICE_SHIFT = 41;
  localparam logic [9:0]  ICE_DEN   = 10'd917;
  localparam logic [8:0]  LEN_SCALE = 9'd500;
  localparam logic [10:0] MIN_PER_DAY = 11'd1440;
  localparam logic [10:0] TS_RESET  = 11'd1440;
  localparam logic [62:0] MAG_MAX   = 63'h4000000000000000;
  localparam logic [62:0] POS_MAX   = 63'h3FFFFFFFFFFFFFFF;

  localparam logic REG_TIMESTEP = 1'b0;

  typedef struct packed {
    logic        valid;
    logic        flat;
    logic        up;
    logic [22:0] h;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] num_g;
    logic [26:0] den_g;
    logic [63:0] num_f;
    logic [16:0] den_f;
    logic [63:0] num_t;
    logic [16:0] den_t;
    logic [63:0] cap_num;
  } front_t;

  typedef struct packed {
    logic                    z;
    logic signed [EXP_W-1:0] e;
    logic [31:0]             m;
  } fnum_t;

endpackage

// File: hdl/gilf_front.sv
// front stages: ice thickness, surface difference, divider operands
module gilf_front import gilf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [21:0] ice_from_mm,
  input  logic [21:0] ice_to_mm,
  input  logic [22:0] init_ice_from_mm,
  input  logic [22:0] init_ice_to_mm,
  input  logic [23:0] elev_from_mm,
  input  logic [23:0] elev_to_mm,
  input  logic [16:0] len_from_m,
  input  logic [16:0] len_to_m,
  input  logic [29:0] area_from_m2,
  input  logic [29:0] area_to_m2,
  output front_t      fo
);

  // stage 1
  logic        v1;
  logic [31:0] xf1, xt1;
  logic [21:0] ifr1, ito1;
  logic [22:0] initf1, initt1;
  logic [23:0] ef1, et1;
  logic [16:0] lf1, lt1;
  logic [29:0] af1, at1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    xf1    <= 32'(ice_from_mm) * 32'(ICE_NUM);
    xt1    <= 32'(ice_to_mm) * 32'(ICE_NUM);
    ifr1   <= ice_from_mm;
    ito1   <= ice_to_mm;
    initf1 <= init_ice_from_mm;
    initt1 <= init_ice_to_mm;
    ef1    <= elev_from_mm;
    et1    <= elev_to_mm;
    lf1    <= (len_from_m == 17'd0) ? 17'd1 : len_from_m;
    lt1    <= (len_to_m == 17'd0) ? 17'd1 : len_to_m;
    af1    <= area_from_m2;
    at1    <= area_to_m2;
  end

  // stage 2: reciprocal product for the divide by 917
  logic        v2;
  logic [63:0] pf2, pt2;
  logic [31:0] xf2, xt2;
  logic [21:0] ifr2, ito2;
  logic [22:0] initf2, initt2;
  logic [23:0] ef2, et2;
  logic [16:0] lf2, lt2;
  logic [29:0] af2, at2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    pf2    <= 64'(xf1) * 64'(ICE_RECIP);
    pt2    <= 64'(xt1) * 64'(ICE_RECIP);
    xf2    <= xf1;
    xt2    <= xt1;
    ifr2   <= ifr1;
    ito2   <= ito1;
    initf2 <= initf1;
    initt2 <= initt1;
    ef2    <= ef1;
    et2    <= et1;
    lf2    <= lf1;
    lt2    <= lt1;
    af2    <= af1;
    at2    <= at1;
  end

  // stage 3: one correction step on the estimate
  logic [22:0] q0f, q0t;
  logic [31:0] rf, rt;
  logic [22:0] hf_next, ht_next;

  always_comb begin
    q0f = pf2[63:ICE_SHIFT];
    q0t = pt2[63:ICE_SHIFT];
    rf  = xf2 - 32'(q0f) * 32'(ICE_DEN);
    rt  = xt2 - 32'(q0t) * 32'(ICE_DEN);
    hf_next = (rf >= 32'(ICE_DEN)) ? q0f + 23'd1 : q0f;
    ht_next = (rt >= 32'(ICE_DEN)) ? q0t + 23'd1 : q0t;
  end

  logic        v3;
  logic [22:0] hf3, ht3;
  logic [21:0] ifr3, ito3;
  logic [22:0] initf3, initt3;
  logic [23:0] ef3, et3;
  logic [16:0] lf3, lt3;
  logic [29:0] af3, at3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    hf3    <= hf_next;
    ht3    <= ht_next;
    ifr3   <= ifr2;
    ito3   <= ito2;
    initf3 <= initf2;
    initt3 <= initt2;
    ef3    <= ef2;
    et3    <= et2;
    lf3    <= lf2;
    lt3    <= lt2;
    af3    <= af2;
    at3    <= at2;
  end

  // stage 4: surfaces, direction and upstream selection
  logic signed [26:0] sf, st, d, negd;
  logic               up_next;

  always_comb begin
    sf = $signed({4'b0, hf3}) + $signed({3'b0, ef3}) - $signed({4'b0, initf3});
    st = $signed({4'b0, ht3}) + $signed({3'b0, et3}) - $signed({4'b0, initt3});
    d  = st - sf;
    negd = -d;
    up_next = d[26];
  end

  logic        v4, flat4, up4;
  logic [24:0] ad4;
  logic [22:0] h4;
  logic [21:0] stor4;
  logic [29:0] area4;
  logic [16:0] lf4, lt4;
  logic [29:0] af4, at4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    flat4 <= (d == 27'sd0);
    up4   <= up_next;
    ad4   <= up_next ? negd[24:0] : d[24:0];
    h4    <= up_next ? hf3 : ht3;
    stor4 <= up_next ? ifr3 : ito3;
    area4 <= up_next ? af3 : at3;
    lf4   <= lf3;
    lt4   <= lt3;
    af4   <= af3;
    at4   <= at3;
  end

  // stage 5: dividends, divisors, storage times area
  logic [17:0] lsum;
  assign lsum = {1'b0, lf4} + {1'b0, lt4};

  side_t       side5;
  logic [63:0] num_g5, num_f5, num_t5;
  logic [26:0] den_g5;
  logic [16:0] den_f5, den_t5;
  logic [51:0] sa5;

  always_ff @(posedge clk) begin
    if (rst) begin
      side5 <= '0;
    end else begin
      side5 <= '{valid: v4, flat: flat4, up: up4, h: h4};
    end
    num_g5 <= {7'b0, ad4, 32'b0};
    den_g5 <= 27'(lsum) * 27'(LEN_SCALE);
    num_f5 <= {10'b0, af4, 24'b0};
    num_t5 <= {10'b0, at4, 24'b0};
    den_f5 <= lf4;
    den_t5 <= lt4;
    sa5    <= 52'(stor4) * 52'(area4);
  end

  // stage 6: scale storage to a day
  always_ff @(posedge clk) begin
    if (rst) begin
      fo.side <= '0;
    end else begin
      fo.side <= side5;
    end
    fo.num_g   <= num_g5;
    fo.den_g   <= den_g5;
    fo.num_f   <= num_f5;
    fo.den_f   <= den_f5;
    fo.num_t   <= num_t5;
    fo.den_t   <= den_t5;
    fo.cap_num <= 64'(sa5) * 64'(MIN_PER_DAY);
  end

endmodule

// File: hdl/gilf_div.sv
// pipelined restoring divider, one quotient bit per stage
module gilf_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] n_s [0:NUM_W];
  logic [DEN_W-1:0] r_s [0:NUM_W-1];
  logic [DEN_W-1:0] d_s [0:NUM_W-1];

  assign n_s[0] = num;
  assign r_s[0] = '0;
  assign d_s[0] = den;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      t    = {r_s[k], n_s[k][NUM_W-1]};
      diff = t - {1'b0, d_s[k]};
      ge   = (t >= {1'b0, d_s[k]});
    end

    always_ff @(posedge clk) begin
      n_s[k+1] <= {n_s[k][NUM_W-2:0], ge};
    end

    if (k < NUM_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        r_s[k+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        d_s[k+1] <= d_s[k];
      end
    end
  end

  assign quo = n_s[NUM_W];

endmodule

// File: hdl/gilf_norm.sv
// three-stage leading-zero normalizer to a 32-bit mantissa and exponent
module gilf_norm import gilf_pkg::*; (
  input  logic        clk,
  input  logic [63:0] v,
  output fnum_t       f
);

  logic [63:0] a1, a2;
  logic        z32, z16;

  always_comb begin
    z32 = (v[63:32] == 32'd0);
    a1  = z32 ? {v[31:0], 32'b0} : v;
    z16 = (a1[63:48] == 16'd0);
    a2  = z16 ? {a1[47:0], 16'b0} : a1;
  end

  logic [63:0] s1;
  logic [1:0]  lz1;
  logic        zero1;

  always_ff @(posedge clk) begin
    s1    <= a2;
    lz1   <= {z32, z16};
    zero1 <= (v == 64'd0);
  end

  logic [63:0] a3, a4;
  logic        z8, z4;

  always_comb begin
    z8 = (s1[63:56] == 8'd0);
    a3 = z8 ? {s1[55:0], 8'b0} : s1;
    z4 = (a3[63:60] == 4'd0);
    a4 = z4 ? {a3[59:0], 4'b0} : a3;
  end

  logic [63:0] s2;
  logic [3:0]  lz2;
  logic        zero2;

  always_ff @(posedge clk) begin
    s2    <= a4;
    lz2   <= {lz1, z8, z4};
    zero2 <= zero1;
  end

  logic [63:0] a5, a6;
  logic        z2, z1;
  logic [5:0]  lz;

  always_comb begin
    z2 = (s2[63:62] == 2'd0);
    a5 = z2 ? {s2[61:0], 2'b0} : s2;
    z1 = ~a5[63];
    a6 = z1 ? {a5[62:0], 1'b0} : a5;
    lz = {lz2, z2, z1};
  end

  always_ff @(posedge clk) begin
    f.z <= zero2;
    f.m <= a6[63:32];
    f.e <= $signed(EXP_W'(32) - EXP_W'(lz));
  end

endmodule

// File: hdl/gilf_prod.sv
// flow-law product chain, magnitude, storage cap and output register
module gilf_prod import gilf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  side_t              side_in,
  input  logic [63:0]        g_in,
  input  logic [53:0]        wq_in,
  input  logic [63:0]        cap_in,
  output logic               done,
  output logic signed [62:0] exchange_rate,
  output logic               storage_limited,
  output logic               flat_surface
);

  fnum_t gn, hn, wn;

  gilf_norm u_norm_g (.clk(clk), .v(g_in), .f(gn));
  gilf_norm u_norm_h (.clk(clk), .v({41'b0, side_in.h}), .f(hn));
  gilf_norm u_norm_w (.clk(clk), .v({10'b0, wq_in}), .f(wn));

  side_t       sn  [0:NORM_LAT-1];
  logic [63:0] cn  [0:NORM_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NORM_LAT; i++) begin
        sn[i] <= '0;
      end
    end else begin
      sn[0] <= side_in;
      for (int i = 1; i < NORM_LAT; i++) begin
        sn[i] <= sn[i-1];
      end
    end
    cn[0] <= cap_in;
    for (int i = 1; i < NORM_LAT; i++) begin
      cn[i] <= cn[i-1];
    end
  end

  fnum_t       acc_s [0:MUL_STAGES];
  fnum_t       g_s   [0:G_COUNT-1];
  fnum_t       h_s   [0:MUL_STAGES-2];
  fnum_t       w_s   [0:MUL_STAGES-1];
  side_t       sd_s  [0:MUL_STAGES];
  logic [63:0] cp_s  [0:MUL_STAGES];

  assign acc_s[0] = '{z: gn.z | hn.z | wn.z, e: K_EXP, m: K_MANT};
  assign g_s[0]   = gn;
  assign h_s[0]   = hn;
  assign w_s[0]   = wn;
  assign sd_s[0]  = sn[NORM_LAT-1];
  assign cp_s[0]  = cn[NORM_LAT-1];

  for (genvar k = 0; k < MUL_STAGES; k++) begin : g_mul
    fnum_t       op;
    fnum_t       nx;
    logic [63:0] p;

    if (k < G_COUNT) begin : g_opg
      assign op = g_s[k];
    end else if (k < MUL_STAGES - 1) begin : g_oph
      assign op = h_s[k];
    end else begin : g_opw
      assign op = w_s[k];
    end

    always_comb begin
      p    = 64'(acc_s[k].m) * 64'(op.m);
      nx.z = acc_s[k].z;
      if (p[63]) begin
        nx.m = p[63:32];
        nx.e = acc_s[k].e + op.e + $signed(EXP_W'(32));
      end else begin
        nx.m = p[62:31];
        nx.e = acc_s[k].e + op.e + $signed(EXP_W'(31));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd_s[k+1] <= '0;
      end else begin
        sd_s[k+1] <= sd_s[k];
      end
      acc_s[k+1] <= nx;
      cp_s[k+1]  <= cp_s[k];
    end

    if (k < G_COUNT - 1) begin : g_keep_g
      always_ff @(posedge clk) begin
        g_s[k+1] <= g_s[k];
      end
    end
    if (k < MUL_STAGES - 2) begin : g_keep_h
      always_ff @(posedge clk) begin
        h_s[k+1] <= h_s[k];
      end
    end
    if (k < MUL_STAGES - 1) begin : g_keep_w
      always_ff @(posedge clk) begin
        w_s[k+1] <= w_s[k];
      end
    end
  end

  // magnitude from mantissa and exponent
  fnum_t                   fin;
  logic [EXP_W-1:0]        ne;
  logic [62:0]             mag_next;

  always_comb begin
    fin = acc_s[MUL_STAGES];
    ne  = EXP_W'(-fin.e);
    if (fin.z) begin
      mag_next = '0;
    end else if (fin.e >= $signed(EXP_W'(31))) begin
      mag_next = MAG_MAX;
    end else if (fin.e >= $signed(EXP_W'(0))) begin
      mag_next = 63'(fin.m) << fin.e[4:0];
    end else if (fin.e <= -10'sd64) begin
      mag_next = '0;
    end else begin
      mag_next = 63'(fin.m) >> ne[5:0];
    end
  end

  side_t       sm;
  logic [62:0] mag;
  logic [63:0] cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm <= '0;
    end else begin
      sm <= sd_s[MUL_STAGES];
    end
    mag <= mag_next;
    cap <= cp_s[MUL_STAGES];
  end

  // storage cap, range clamp, sign
  logic        lim;
  logic [62:0] magc, clamped, rate_next;

  always_comb begin
    lim  = ~sm.flat && (64'(mag) > cap);
    magc = lim ? cap[62:0] : mag;
    if (sm.up) begin
      clamped   = (magc > POS_MAX) ? POS_MAX : magc;
      rate_next = clamped;
    end else begin
      clamped   = (magc > MAG_MAX) ? MAG_MAX : magc;
      rate_next = 63'd0 - clamped;
    end
    if (sm.flat) begin
      rate_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sm.valid;
    end
    exchange_rate   <= $signed(rate_next);
    storage_limited <= lim;
    flat_surface    <= sm.flat;
  end

endmodule

// File: hdl/glacier_ice_lateral_flux_core.sv
// top level of the glacier ice lateral flux pipeline
//
// one connection word is taken at each rising edge where start is high
// and busy is low; busy stays low, so a new word may enter every cycle
// the result word (exchange_rate, storage_limited, flat_surface) shows
// for one cycle with done high
// throughput is one word per cycle; the path runs through the four
// 64-stage restoring dividers (gradient, two widths, storage cap)
// plus six front stages, one width-sum stage, three normalizer stages,
// nine mantissa multiplies and two output stages
// the receiver cannot hold results off, so nothing ever stalls
// reset (rst, synchronous) clears every valid bit in flight and sets
// timestep_minutes back to 1440
// timestep_minutes sits at byte address 0 of the apb-style port;
// write it only while no word is in flight
module glacier_ice_lateral_flux_core import gilf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // connection word
  input  logic               start,
  output logic               busy,
  input  logic [21:0]        ice_from_mm,
  input  logic [21:0]        ice_to_mm,
  input  logic [22:0]        init_ice_from_mm,
  input  logic [22:0]        init_ice_to_mm,
  input  logic [23:0]        elev_from_mm,
  input  logic [23:0]        elev_to_mm,
  input  logic [16:0]        len_from_m,
  input  logic [16:0]        len_to_m,
  input  logic [29:0]        area_from_m2,
  input  logic [29:0]        area_to_m2,
  // result word
  output logic               done,
  output logic signed [62:0] exchange_rate,
  output logic               storage_limited,
  output logic               flat_surface,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // nothing downstream can stall, so the pipe always accepts
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // timestep register
  logic [10:0] timestep_minutes;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timestep_minutes <= TS_RESET;
    end else if (cfg_wr && (paddr[2] == REG_TIMESTEP)) begin
      timestep_minutes <= pwdata[10:0];
    end
  end

  assign prdata = (paddr[2] == REG_TIMESTEP) ? {21'b0, timestep_minutes} : 32'd0;

  // front: thickness, gradient sign, divider operands
  front_t fo;

  gilf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (start && !busy),
    .ice_from_mm      (ice_from_mm),
    .ice_to_mm        (ice_to_mm),
    .init_ice_from_mm (init_ice_from_mm),
    .init_ice_to_mm   (init_ice_to_mm),
    .elev_from_mm     (elev_from_mm),
    .elev_to_mm       (elev_to_mm),
    .len_from_m       (len_from_m),
    .len_to_m         (len_to_m),
    .area_from_m2     (area_from_m2),
    .area_to_m2       (area_to_m2),
    .fo               (fo)
  );

  // four dividers run side by side with equal depth
  logic [63:0] g_q, wf_q, wt_q, cap_q;
  logic [10:0] tm_div;

  // a zero timestep is taken as one minute
  assign tm_div = (timestep_minutes == 11'd0) ? 11'd1 : timestep_minutes;

  gilf_div #(.NUM_W(DIV_W), .DEN_W(27)) u_div_g (
    .clk (clk), .num (fo.num_g), .den (fo.den_g), .quo (g_q)
  );
  gilf_div #(.NUM_W(DIV_W), .DEN_W(17)) u_div_wf (
    .clk (clk), .num (fo.num_f), .den (fo.den_f), .quo (wf_q)
  );
  gilf_div #(.NUM_W(DIV_W), .DEN_W(17)) u_div_wt (
    .clk (clk), .num (fo.num_t), .den (fo.den_t), .quo (wt_q)
  );
  gilf_div #(.NUM_W(DIV_W), .DEN_W(11)) u_div_cap (
    .clk (clk), .num (fo.cap_num), .den (tm_div), .quo (cap_q)
  );

  // control and thickness ride alongside the dividers
  side_t side_d [0:DIV_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_W; i++) begin
        side_d[i] <= '0;
      end
    end else begin
      side_d[0] <= fo.side;
      for (int i = 1; i < DIV_W; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // mean width in q24
  logic [54:0] wsum;
  assign wsum = 55'(wf_q) + 55'(wt_q);

  side_t       b_side;
  logic [63:0] b_g, b_cap;
  logic [53:0] b_wq;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_side <= '0;
    end else begin
      b_side <= side_d[DIV_W-1];
    end
    b_g   <= g_q;
    b_wq  <= wsum[54:1];
    b_cap <= cap_q;
  end

  // flow law product and output
  gilf_prod u_prod (
    .clk             (clk),
    .rst             (rst),
    .side_in         (b_side),
    .g_in            (b_g),
    .wq_in           (b_wq),
    .cap_in          (b_cap),
    .done            (done),
    .exchange_rate   (exchange_rate),
    .storage_limited (storage_limited),
    .flat_surface    (flat_surface)
  );

endmodule

// File: hdl/gilf_checker.sv
// port-level checks on the glacier ice lateral flux core, with bind
module gilf_checker import gilf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [62:0] exchange_rate,
  input logic               storage_limited,
  input logic               flat_surface
);

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word did not come out on time");

  // no result without an accepted word
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted word");

  // a flat surface carries no flux and no storage cut
  a_flat: assert property (@(posedge clk) disable iff (rst)
    (done && flat_surface) |-> (exchange_rate == 63'sd0 && !storage_limited))
    else $error("flat surface with nonzero flux");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

endmodule

bind glacier_ice_lateral_flux_core gilf_checker u_gilf_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .exchange_rate   (exchange_rate),
  .storage_limited (storage_limited),
  .flat_surface    (flat_surface)
);

// File: test/tb.sv
// testbench for the glacier ice lateral flux core
module tb import gilf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // one connection word as driven onto the input ports
  typedef struct {
    logic [21:0] ice_f;
    logic [21:0] ice_t;
    logic [22:0] init_f;
    logic [22:0] init_t;
    logic [23:0] elev_f;
    logic [23:0] elev_t;
    logic [16:0] len_f;
    logic [16:0] len_t;
    logic [29:0] area_f;
    logic [29:0] area_t;
  } conn_t;

  // one predicted result word
  typedef struct {
    logic signed [62:0] rate;
    logic               limited;
    logic               flat;
  } flux_t;

  // mantissa with binary exponent, as the block's multiply chain keeps it
  typedef struct {
    logic [63:0] m;
    int          e;
  } mant_t;

  localparam int MAX_CYCLES = 2000000;
  localparam int DRAIN      = LATENCY + 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [21:0] ice_from_mm = '0, ice_to_mm = '0;
  logic [22:0] init_ice_from_mm = '0, init_ice_to_mm = '0;
  logic [23:0] elev_from_mm = '0, elev_to_mm = '0;
  logic [16:0] len_from_m = '0, len_to_m = '0;
  logic [29:0] area_from_m2 = '0, area_to_m2 = '0;
  logic done;
  logic signed [62:0] exchange_rate;
  logic storage_limited, flat_surface;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  glacier_ice_lateral_flux_core i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor copy of the timestep register
  logic [10:0] step_minutes;

  conn_t pending_conns[$];
  flux_t expected_flux[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 0;

  function automatic mant_t norm(logic [63:0] v, int e);
    mant_t r;
    r.m = v;
    r.e = e;
    if (v == 0) begin
      r.e = 0;
      return r;
    end
    while (r.m >= 64'h1_0000_0000) begin
      r.m = r.m >> 1;
      r.e++;
    end
    while (r.m < 64'h8000_0000) begin
      r.m = r.m << 1;
      r.e--;
    end
    return r;
  endfunction

  function automatic mant_t mant_mul(mant_t a, mant_t b);
    if (a.m == 0 || b.m == 0) return norm(0, 0);
    return norm(a.m * b.m, a.e + b.e);
  endfunction

  // flux predicted for one connection at the current timestep
  function automatic flux_t predict_flux(conn_t c);
    flux_t r;
    logic [63:0] hf, ht, ad, g, wq, h, cap, mag, stor, area, lf, lt, tm;
    longint sf, st, d;
    bit up;
    mant_t f;
    r.limited = 1'b0;
    r.flat = 1'b0;
    hf = 64'(c.ice_f) * 1000 / 917;
    ht = 64'(c.ice_t) * 1000 / 917;
    sf = longint'(hf) + longint'(c.elev_f) - longint'(c.init_f);
    st = longint'(ht) + longint'(c.elev_t) - longint'(c.init_t);
    d = st - sf;
    lf = (c.len_f == 0) ? 64'd1 : 64'(c.len_f);
    lt = (c.len_t == 0) ? 64'd1 : 64'(c.len_t);
    if (d == 0) begin
      r.rate = '0;
      r.flat = 1'b1;
      return r;
    end
    up = d < 0;
    ad = up ? 64'(-d) : 64'(d);
    g = (ad << 32) / (500 * (lf + lt));
    wq = (((64'(c.area_f) << 24) / lf) + ((64'(c.area_t) << 24) / lt)) >> 1;
    h = up ? hf : ht;
    f = norm(64'd2391936205, -215);
    for (int i = 0; i < 3; i++) f = mant_mul(f, norm(g, 0));
    for (int i = 0; i < 5; i++) f = mant_mul(f, norm(h, 0));
    f = mant_mul(f, norm(wq, 0));
    if (f.m == 0) mag = 0;
    else if (f.e >= 31) mag = 64'h4000_0000_0000_0000;
    else if (f.e >= 0) mag = f.m << f.e;
    else if (f.e <= -64) mag = 0;
    else mag = f.m >> (-f.e);
    stor = up ? 64'(c.ice_f) : 64'(c.ice_t);
    area = up ? 64'(c.area_f) : 64'(c.area_t);
    tm = (step_minutes == 0) ? 64'd1 : 64'(step_minutes);
    cap = stor * area * 1440 / tm;
    if (mag > cap) begin
      mag = cap;
      r.limited = 1'b1;
    end
    if (up) begin
      if (mag > 64'h3FFF_FFFF_FFFF_FFFF) mag = 64'h3FFF_FFFF_FFFF_FFFF;
      r.rate = mag[62:0];
    end else begin
      if (mag > 64'h4000_0000_0000_0000) mag = 64'h4000_0000_0000_0000;
      r.rate = 63'(64'd0 - mag);
    end
    return r;
  endfunction

  // driver: offers queued words with random gaps
  always @(posedge clk) begin
    conn_t c;
    if (rst) begin
      start <= 1'b0;
    end else begin
      // word on the ports is taken at this edge
      if (start && !busy) expected_flux.push_back(predict_flux(pending_conns.pop_front()));
      if (pending_conns.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_conns[0];
        start <= 1'b1;
        ice_from_mm <= c.ice_f;
        ice_to_mm <= c.ice_t;
        init_ice_from_mm <= c.init_f;
        init_ice_to_mm <= c.init_t;
        elev_from_mm <= c.elev_f;
        elev_to_mm <= c.elev_t;
        len_from_m <= c.len_f;
        len_to_m <= c.len_t;
        area_from_m2 <= c.area_f;
        area_to_m2 <= c.area_t;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks each result word against the oldest prediction
  always @(posedge clk) begin
    flux_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_flux.size() == 0) begin
        $display("%0t: unexpected word rate=%0d", $time, exchange_rate);
        error_count++;
      end else begin
        e = expected_flux.pop_front();
        if (exchange_rate !== e.rate) begin
          $display("%0t: exchange_rate expected %0d actual %0d", $time, e.rate, exchange_rate);
          error_count++;
        end
        if (storage_limited !== e.limited) begin
          $display("%0t: storage_limited expected %0b actual %0b", $time, e.limited,
                   storage_limited);
          error_count++;
        end
        if (flat_surface !== e.flat) begin
          $display("%0t: flat_surface expected %0b actual %0b", $time, e.flat, flat_surface);
          error_count++;
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic conn_t rand_conn();
    conn_t c;
    c.ice_f = $urandom_range(4000000);
    c.ice_t = $urandom_range(4000000);
    c.init_f = $urandom_range(4400000);
    c.init_t = $urandom_range(4400000);
    c.elev_f = $urandom_range(9000000);
    c.elev_t = $urandom_range(9000000);
    c.len_f = $urandom_range(100000, 1);
    c.len_t = $urandom_range(100000, 1);
    c.area_f = $urandom_range(1000000000, 1);
    c.area_t = $urandom_range(1000000000, 1);
    case ($urandom_range(9))
      // raw bits of every field, out of range too
      0: begin
        c.ice_f = $urandom; c.ice_t = $urandom; c.init_f = $urandom; c.init_t = $urandom;
        c.elev_f = $urandom; c.elev_t = $urandom; c.len_f = $urandom; c.len_t = $urandom;
        c.area_f = $urandom; c.area_t = $urandom;
      end
      // flat surface: same surface on both sides
      1: begin
        c.ice_t = c.ice_f; c.init_t = c.init_f; c.elev_t = c.elev_f;
      end
      // gentle slope so the flux stays below the storage cap
      2: c.elev_t = c.elev_f + $urandom_range(2000) - 1000;
      3: begin
        c.ice_f = $urandom_range(50000); c.ice_t = $urandom_range(50000);
        c.init_f = $urandom_range(50000); c.init_t = $urandom_range(50000);
        c.elev_t = c.elev_f - $urandom_range(20000);
      end
      default: ;
    endcase
    return c;
  endfunction

  // apb write while the pipeline is empty
  task automatic write_timestep(logic [10:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'(REG_TIMESTEP) << 2;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    step_minutes = v;
  endtask

  // wait until every queued word is taken and its result has come
  task automatic drain();
    while (pending_conns.size() > 0 || expected_flux.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    conn_t c;
    logic [10:0] steps[5];
    steps = '{11'd1, 11'd1440, 11'd2047, 11'd0, 11'd60};
    step_minutes = TS_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, flat, both directions, zero lengths and areas
    c = '{4000000, 0, 0, 4400000, 9000000, 0, 100000, 100000, 1000000000, 1000000000};
    pending_conns.push_back(c);
    c = '{0, 4000000, 4400000, 0, 0, 9000000, 1, 1, 1, 1};
    pending_conns.push_back(c);
    c = '{1000, 1000, 5, 5, 700, 700, 10, 10, 100, 100};
    pending_conns.push_back(c);
    c = '{4000000, 4000000, 0, 0, 9000000, 0, 0, 0, 0, 0};
    pending_conns.push_back(c);
    c = '{22'h3FFFFF, 22'h3FFFFF, 23'h7FFFFF, 0, 24'hFFFFFF, 0, 17'h1FFFF, 17'h1FFFF,
          30'h3FFFFFFF, 30'h3FFFFFFF};
    pending_conns.push_back(c);
    c = '{0, 0, 0, 0, 1000, 1001, 1000, 1000, 1000000, 1000000};
    pending_conns.push_back(c);
    c = '{2000000, 0, 0, 0, 5000000, 4999000, 1, 1, 1000000000, 1000000000};
    pending_conns.push_back(c);
    c = '{0, 3000, 0, 0, 500, 520, 5000, 5000, 100, 100};
    pending_conns.push_back(c);
    drain();
    // several timestep settings, each with an idling mix of 0, 15 or 85 percent
    for (int p = 0; p < 5; p++) begin
      write_timestep(steps[p]);
      send_idle_pct = (p == 1 || p == 2) ? 85 : (p == 3 ? 15 : 0);
      for (int i = 0; i < 350; i++) pending_conns.push_back(rand_conn());
      drain();
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: glacier_ice_lateral_flux_core.f
hdl/gilf_pkg.sv
hdl/gilf_front.sv
hdl/gilf_div.sv
hdl/gilf_norm.sv
hdl/gilf_prod.sv
hdl/glacier_ice_lateral_flux_core.sv
hdl/gilf_checker.sv
test/tb.sv
